// ----- src/pwdf_pkg.sv -----
// Shared types and constants for the pulse width digit frame decoder.
// No dependencies; used by every module in src.
package pwdf_pkg;

  localparam int unsigned TICK_W  = 16;
  localparam int unsigned STEP_W  = 13;
  localparam int unsigned VALUE_W = 10;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned COUNT_W = 2;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned EDGE_W  = 18;  // upper edge + 9 steps, no truncation
  localparam int unsigned NUM_WIN = 9;   // digit windows above zero

  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [TICK_W-1:0] START_LOW_RST        = 16'd5050;
  localparam logic [TICK_W-1:0] START_HIGH_RST       = 16'd5550;
  localparam logic [TICK_W-1:0] DIGIT_MIN_RST        = 16'd100;
  localparam logic [TICK_W-1:0] DIGIT_ZERO_UPPER_RST = 16'd550;
  localparam logic [STEP_W-1:0] DIGIT_STEP_RST       = 13'd500;

  localparam logic [VALUE_W-1:0] TENS_WEIGHT     = 10'd10;
  localparam logic [VALUE_W-1:0] HUNDREDS_WEIGHT = 10'd100;
  localparam logic [VALUE_W-1:0] VALUE_MAX       = 10'd999;

  localparam logic [COUNT_W-1:0] CNT_UNITS    = 2'd0;
  localparam logic [COUNT_W-1:0] CNT_TENS     = 2'd1;
  localparam logic [COUNT_W-1:0] CNT_HUNDREDS = 2'd2;

  typedef enum logic [IDX_W-1:0] {
    REG_START_LOW        = 3'd0,
    REG_START_HIGH       = 3'd1,
    REG_DIGIT_MIN        = 3'd2,
    REG_DIGIT_ZERO_UPPER = 3'd3,
    REG_DIGIT_STEP       = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_FRAME = 1'b1
  } frame_state_t;

  typedef struct packed {
    logic [TICK_W-1:0] start_low;
    logic [TICK_W-1:0] start_high;
    logic [TICK_W-1:0] digit_min;
    logic [TICK_W-1:0] digit_zero_upper;
    logic [STEP_W-1:0] digit_step;
  } cfg_t;

  typedef struct packed {
    logic               start_hit;  // width inside the start window
    logic [DIGIT_W-1:0] digit;      // decoded digit, last digit if no window hit
  } class_t;

endpackage

// ----- src/pwdf_cfg_regs.sv -----
// Configuration register bank of the pulse width digit frame decoder.
// Depends on pwdf_pkg.
module pwdf_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               wr_en,
  input  logic [pwdf_pkg::IDX_W-1:0]         wr_index,
  input  logic [pwdf_pkg::CFG_DATA_W-1:0]    wr_data,
  output pwdf_pkg::cfg_t                     cfg
);

  pwdf_pkg::cfg_t cfg_r;
  pwdf_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (pwdf_pkg::cfg_reg_t'(wr_index))
        pwdf_pkg::REG_START_LOW:        cfg_nxt.start_low        = wr_data;
        pwdf_pkg::REG_START_HIGH:       cfg_nxt.start_high       = wr_data;
        pwdf_pkg::REG_DIGIT_MIN:        cfg_nxt.digit_min        = wr_data;
        pwdf_pkg::REG_DIGIT_ZERO_UPPER: cfg_nxt.digit_zero_upper = wr_data;
        pwdf_pkg::REG_DIGIT_STEP:
          cfg_nxt.digit_step = wr_data[pwdf_pkg::STEP_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_low        <= pwdf_pkg::START_LOW_RST;
      cfg_r.start_high       <= pwdf_pkg::START_HIGH_RST;
      cfg_r.digit_min        <= pwdf_pkg::DIGIT_MIN_RST;
      cfg_r.digit_zero_upper <= pwdf_pkg::DIGIT_ZERO_UPPER_RST;
      cfg_r.digit_step       <= pwdf_pkg::DIGIT_STEP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- src/pwdf_classify.sv -----
// Window classifier: sorts one pulse width into start window and digit 0..9.
// Depends on pwdf_pkg.
module pwdf_classify (
  input  logic [pwdf_pkg::TICK_W-1:0]  width,
  input  pwdf_pkg::cfg_t               cfg,
  input  logic [pwdf_pkg::DIGIT_W-1:0] last_digit,
  output pwdf_pkg::class_t             cls
);

  localparam int unsigned EW = pwdf_pkg::EDGE_W;

  logic [EW-1:0]             edges [1:pwdf_pkg::NUM_WIN];
  logic [pwdf_pkg::NUM_WIN:1] above;
  logic [EW-1:0]             w_ext;
  logic                      zero_hit;
  logic                      upper_hit;
  logic [pwdf_pkg::DIGIT_W-1:0] win_cnt;

  assign w_ext = EW'(width);

  // Upper edge of each digit window: zero_upper + k * step, full width.
  always_comb begin
    for (int k = 1; k <= pwdf_pkg::NUM_WIN; k++) begin
      edges[k] = EW'(cfg.digit_zero_upper) + EW'(cfg.digit_step) * EW'(k);
      above[k] = w_ext > edges[k];
    end
  end

  // Edges are monotone for a non-zero step, so the digit is one more than
  // the number of inner edges the width lies above.
  always_comb begin
    win_cnt = pwdf_pkg::DIGIT_W'(1);
    for (int k = 1; k < pwdf_pkg::NUM_WIN; k++) begin
      win_cnt = win_cnt + pwdf_pkg::DIGIT_W'(above[k]);
    end
  end

  assign zero_hit  = (width >= cfg.digit_min) && (width <= cfg.digit_zero_upper);
  assign upper_hit = (width > cfg.digit_zero_upper) && (cfg.digit_step != '0) &&
                     !above[pwdf_pkg::NUM_WIN];

  always_comb begin
    cls.start_hit = (width > cfg.start_low) && (width <= cfg.start_high);
    priority if (zero_hit) begin
      cls.digit = '0;
    end else if (upper_hit) begin
      cls.digit = win_cnt;
    end else begin
      cls.digit = last_digit;
    end
  end

endmodule

// ----- src/pulse_width_digit_frame_decoder_core.sv -----
// Top level of the pulse width digit frame decoder.
// Depends on pwdf_pkg, pwdf_cfg_regs and pwdf_classify.

// Takes one measured pulse width per input transfer and sustains one transfer
// per clock while the result stream is not stalled. Each width is captured in an
// input register; the classifier and the frame state update then act on it in
// one pass and any finished value lands in the result register. The loop
// through the frame state (idle/frame, digit count, partial value, last digit)
// is closed in one pass per item, which sets the one-item-per-clock rate. While
// idle, a width with start_low < w <= start_high opens a frame and carries no
// digit; then three widths give the units, tens and hundreds digits and the
// value is sent out. A width that falls in no digit window repeats the last
// digit. The input side keeps taking transfers while a result waits, until
// both the input and result registers are full. Configuration writes are
// always accepted and should only be made while no item is in flight. No
// clearing pass after reset.
module pulse_width_digit_frame_decoder_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream; tdata[15:0] = pulse_ticks
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [pwdf_pkg::IN_TDATA_W-1:0]     in_tdata,
  // result stream; tdata[9:0] = value, tdata[15:10] = zero
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [pwdf_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pwdf_pkg::IDX_W-1:0]          cfg_index,
  input  logic [pwdf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int unsigned VW = pwdf_pkg::VALUE_W;

  pwdf_pkg::cfg_t   cfg;
  pwdf_pkg::class_t cls;

  // input register
  logic                        s1_valid_r;
  logic [pwdf_pkg::TICK_W-1:0] s1_pulse_r;

  // frame state
  pwdf_pkg::frame_state_t        state_r,       state_nxt;
  logic [pwdf_pkg::COUNT_W-1:0]  digit_count_r, digit_count_nxt;
  logic [VW-1:0]                 partial_r,     partial_nxt;
  logic [pwdf_pkg::DIGIT_W-1:0]  last_digit_r,  last_digit_nxt;

  // result register
  logic          out_valid_r;
  logic [VW-1:0] out_value_r;
  logic          res_valid;
  logic [VW-1:0] res_value;

  logic advance;   // result register free or being emptied
  logic fire;      // input register item processed this cycle

  assign cfg_ready = 1'b1;

  pwdf_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  pwdf_classify u_class (
    .width      (s1_pulse_r),
    .cfg        (cfg),
    .last_digit (last_digit_r),
    .cls        (cls)
  );

  assign advance   = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_pulse_r <= in_tdata[pwdf_pkg::TICK_W-1:0];
    end
  end

  // next frame state
  always_comb begin
    state_nxt = state_r;
    if (fire) begin
      unique case (state_r)
        pwdf_pkg::ST_IDLE:
          if (cls.start_hit) state_nxt = pwdf_pkg::ST_FRAME;
        pwdf_pkg::ST_FRAME:
          if (digit_count_r == pwdf_pkg::CNT_HUNDREDS) state_nxt = pwdf_pkg::ST_IDLE;
        default: state_nxt = pwdf_pkg::ST_IDLE;
      endcase
    end
  end

  // digit accumulation and result
  always_comb begin
    digit_count_nxt = digit_count_r;
    partial_nxt     = partial_r;
    last_digit_nxt  = last_digit_r;
    res_valid       = 1'b0;
    res_value       = VW'(cls.digit) * pwdf_pkg::HUNDREDS_WEIGHT + partial_r;
    if (fire && state_r == pwdf_pkg::ST_FRAME) begin
      last_digit_nxt = cls.digit;
      unique case (digit_count_r)
        pwdf_pkg::CNT_UNITS: begin
          partial_nxt     = VW'(cls.digit);
          digit_count_nxt = pwdf_pkg::CNT_TENS;
        end
        pwdf_pkg::CNT_TENS: begin
          partial_nxt     = VW'(cls.digit) * pwdf_pkg::TENS_WEIGHT + partial_r;
          digit_count_nxt = pwdf_pkg::CNT_HUNDREDS;
        end
        default: begin
          res_valid       = 1'b1;
          partial_nxt     = '0;
          digit_count_nxt = pwdf_pkg::CNT_UNITS;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= pwdf_pkg::ST_IDLE;
      digit_count_r <= pwdf_pkg::CNT_UNITS;
      partial_r     <= '0;
      last_digit_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      digit_count_r <= digit_count_nxt;
      partial_r     <= partial_nxt;
      last_digit_r  <= last_digit_nxt;
      if (advance) out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_value_r <= res_value;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = pwdf_pkg::OUT_TDATA_W'(out_value_r);

`ifndef NO_ASSERTIONS
  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_value_r <= pwdf_pkg::VALUE_MAX)
    else $error("result value above 999");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    digit_count_r != 2'd3)
    else $error("digit count out of range");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pwdf_pkg::ST_IDLE |-> (digit_count_r == pwdf_pkg::CNT_UNITS &&
                                      partial_r == '0))
    else $error("idle with digits pending");

  a_result_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res_valid) |=> (out_valid_r && state_r == pwdf_pkg::ST_IDLE))
    else $error("result without frame closing");

  a_no_result_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !fire)
    else $error("item processed while result stalled");
`endif

endmodule
